[design/chr_pkg.sv]
// ----------------------------------------------------------------------------
// chr_pkg - shared types and constants of the CRC-32 hash ring
// Function codes, status codes, payload structs, state encoding and CRC step.
// ----------------------------------------------------------------------------
package chr_pkg;

  localparam int RING_DEPTH_DEF = 256;
  localparam int NODE_COUNT_DEF = 16;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NO_NODE = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       last;
    logic [3:0] node_id;
  } chr_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  owner_node;
    logic [31:0] hash_value;
  } chr_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,   // binary search: issue read of mid
    S_SCMP,   // binary search: compare mid
    S_DECIDE, // read data of lower bound index available
    S_SHIFT,  // shift entries up by one for insert
    S_REMOVE, // compaction sweep
    S_DONE
  } chr_state_t;

  // one byte through the reflected CRC-32
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[design/crc32_consistent_hash_ring.sv]
// ----------------------------------------------------------------------------
// crc32_consistent_hash_ring - consistent-hash ring keyed by CRC-32
// Streams key and name bytes, keeps a sorted ring of points in one RAM.
// ----------------------------------------------------------------------------
// A byte that is not the last of a key or name leaves busy low. Every
// other transfer raises busy, and its result is strobed on out_valid for
// one cycle straight after busy falls; the receiver cannot stall it. The
// last byte of a lookup or insert runs a binary search over the ring RAM,
// each probe a read of mid through its registered read port (S_SRCH) and
// a compare (S_SCMP). An insert that lands before the last point then
// shifts the entries from there up by one (S_SHIFT). A remove sweeps every
// point once. A clear, or a lookup on an empty ring, goes straight to
// S_DONE. The RAM needs no clearing after reset: only entries below the
// point count are ever used.
module crc32_consistent_hash_ring #(
  parameter int RING_DEPTH = chr_pkg::RING_DEPTH_DEF,
  parameter int NODE_COUNT = chr_pkg::NODE_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  chr_pkg::chr_in_t in_data,
  output logic             out_valid,
  output chr_pkg::chr_out_t out_data
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);

  // node id reduced into range by repeated subtraction
  function automatic logic [3:0] node_wrap(input logic [3:0] n);
    logic [8:0] v;
    v = {5'd0, n};
    for (int i = 0; i < 8; i++) begin
      if (v >= 9'(NODE_COUNT)) v = v - 9'(NODE_COUNT);
    end
    return v[3:0];
  endfunction

  // ring RAM: hash and owner per point
  logic [35:0] ram [RING_DEPTH];
  logic [35:0] rd_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [35:0]   wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ram[wr_addr] <= wr_data;
    end
    rd_q <= ram[rd_addr];
  end

  chr_pkg::chr_state_t state_r, state_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt, wp_r, wp_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic [3:0]  node_r, node_nxt;
  logic        ins_r, ins_nxt;
  logic        rm_first_r, rm_first_nxt;
  logic [35:0] carry_r, carry_nxt;
  chr_pkg::chr_out_t res_r, res_nxt;
  logic        vld_r, vld_nxt;

  logic          acc;
  logic [31:0]   crc_b;
  logic [CW-1:0] mid;
  logic [3:0]    node_in;

  assign acc     = start && !busy;
  assign crc_b   = chr_pkg::crc_byte(crc_r, in_data.data_byte);
  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign node_in = node_wrap(in_data.node_id);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      chr_pkg::S_IDLE: begin
        if (acc) begin
          if (in_data.func == chr_pkg::FUNC_REMOVE) state_nxt = chr_pkg::S_REMOVE;
          else if (in_data.func == chr_pkg::FUNC_CLEAR) state_nxt = chr_pkg::S_DONE;
          else if (in_data.last) begin
            if (in_data.func == chr_pkg::FUNC_LOOKUP && cnt_r == '0)
              state_nxt = chr_pkg::S_DONE;
            else state_nxt = chr_pkg::S_SRCH;
          end
        end
      end
      chr_pkg::S_SRCH:   state_nxt = (lo_r < hi_r) ? chr_pkg::S_SCMP : chr_pkg::S_DECIDE;
      chr_pkg::S_SCMP:   state_nxt = chr_pkg::S_SRCH;
      chr_pkg::S_DECIDE: begin
        if (ins_r && lo_r < cnt_r && rd_q[35:4] == hash_r) state_nxt = chr_pkg::S_DONE;
        else if (ins_r && cnt_r < CW'(RING_DEPTH) && lo_r < cnt_r)
          state_nxt = chr_pkg::S_SHIFT;
        else state_nxt = chr_pkg::S_DONE;
      end
      chr_pkg::S_SHIFT:  state_nxt = (ptr_r == cnt_r) ? chr_pkg::S_DONE : chr_pkg::S_SHIFT;
      chr_pkg::S_REMOVE: state_nxt = (ptr_r == cnt_r && !rm_first_r) ? chr_pkg::S_DONE
                                                                      : chr_pkg::S_REMOVE;
      chr_pkg::S_DONE:   state_nxt = chr_pkg::S_IDLE;
      default:           state_nxt = chr_pkg::S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    crc_nxt = crc_r;  cnt_nxt = cnt_r;  lo_nxt = lo_r;  hi_nxt = hi_r;
    ptr_nxt = ptr_r;  wp_nxt = wp_r;  hash_nxt = hash_r;  node_nxt = node_r;
    ins_nxt = ins_r;  rm_first_nxt = rm_first_r;  carry_nxt = carry_r;
    res_nxt = res_r;  vld_nxt = 1'b0;
    rd_addr = mid[AW-1:0];  wr_en = 1'b0;  wr_addr = '0;  wr_data = '0;
    unique case (state_r)
      chr_pkg::S_IDLE: begin
        if (acc) begin
          node_nxt = node_in;
          res_nxt  = '0;
          lo_nxt   = '0;
          hi_nxt   = cnt_r;
          ptr_nxt  = '0;
          wp_nxt   = '0;
          rm_first_nxt = 1'b1;
          if (in_data.func == chr_pkg::FUNC_REMOVE) begin
            crc_nxt = chr_pkg::CRC_INIT;
          end else if (in_data.func == chr_pkg::FUNC_CLEAR) begin
            crc_nxt = chr_pkg::CRC_INIT;
            cnt_nxt = '0;
          end else if (in_data.last) begin
            crc_nxt  = chr_pkg::CRC_INIT;
            hash_nxt = ~crc_b;
            ins_nxt  = (in_data.func == chr_pkg::FUNC_INSERT);
            res_nxt.hash_value = ~crc_b;
            if (in_data.func == chr_pkg::FUNC_LOOKUP && cnt_r == '0)
              res_nxt.status = chr_pkg::ST_EMPTY;
          end else begin
            crc_nxt = crc_b;
          end
        end
      end
      chr_pkg::S_SRCH: begin
        rd_addr = mid[AW-1:0];
        if (!(lo_r < hi_r)) begin
          // fetch the bound entry, or entry 0 on wrap for lookup
          rd_addr = (!ins_r && lo_r >= cnt_r) ? '0 : lo_r[AW-1:0];
        end
      end
      chr_pkg::S_SCMP: begin
        if (rd_q[35:4] < hash_r) lo_nxt = mid + 1'b1;
        else hi_nxt = mid;
      end
      chr_pkg::S_DECIDE: begin
        if (!ins_r) begin
          res_nxt.owner_node = rd_q[3:0];
        end else if (lo_r < cnt_r && rd_q[35:4] == hash_r) begin
          wr_en = 1'b1;  wr_addr = lo_r[AW-1:0];  wr_data = {hash_r, node_r};
        end else if (cnt_r >= CW'(RING_DEPTH)) begin
          res_nxt.status = chr_pkg::ST_FULL;
        end else begin
          // write new point, carry the displaced one upward
          wr_en = 1'b1;  wr_addr = lo_r[AW-1:0];  wr_data = {hash_r, node_r};
          carry_nxt = rd_q;
          ptr_nxt = lo_r + 1'b1;
          rd_addr = (lo_r + 1'b1 < CW'(RING_DEPTH)) ? AW'(lo_r + 1'b1) : '0;
          if (lo_r == cnt_r) cnt_nxt = cnt_r + 1'b1;
        end
      end
      chr_pkg::S_SHIFT: begin
        wr_en = 1'b1;  wr_addr = ptr_r[AW-1:0];  wr_data = carry_r;
        carry_nxt = rd_q;
        ptr_nxt = ptr_r + 1'b1;
        rd_addr = (ptr_r + 1'b1 < CW'(RING_DEPTH)) ? AW'(ptr_r + 1'b1) : '0;
        if (ptr_r == cnt_r) cnt_nxt = cnt_r + 1'b1;
      end
      chr_pkg::S_REMOVE: begin
        // read ptr, then compact the entry read last cycle
        rd_addr = (ptr_r < CW'(RING_DEPTH)) ? ptr_r[AW-1:0] : '0;
        rm_first_nxt = 1'b0;
        if (!rm_first_r && ptr_r != '0) begin
          if (rd_q[3:0] != node_r) begin
            wr_en = 1'b1;  wr_addr = wp_r[AW-1:0];  wr_data = rd_q;
            wp_nxt = wp_r + 1'b1;
          end
        end
        if (ptr_r == cnt_r && !rm_first_r) begin
          res_nxt.status = (wp_nxt == cnt_r) ? chr_pkg::ST_NO_NODE : chr_pkg::ST_OK;
          cnt_nxt = wp_nxt;
        end else if (!rm_first_r || cnt_r != '0) begin
          ptr_nxt = ptr_r + 1'b1;
        end else begin
          rm_first_nxt = 1'b0;
        end
      end
      chr_pkg::S_DONE: vld_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= chr_pkg::S_IDLE;
      crc_r   <= chr_pkg::CRC_INIT;
      cnt_r   <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      crc_r   <= crc_nxt;
      cnt_r   <= cnt_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;  hi_r <= hi_nxt;  ptr_r <= ptr_nxt;  wp_r <= wp_nxt;
    hash_r <= hash_nxt;  node_r <= node_nxt;  ins_r <= ins_nxt;
    rm_first_r <= rm_first_nxt;  carry_r <= carry_nxt;  res_r <= res_nxt;
  end

  assign busy      = (state_r != chr_pkg::S_IDLE);
  assign out_valid = vld_r;
  assign out_data  = res_r;

endmodule

[design/chr_checker.sv]
// ----------------------------------------------------------------------------
// chr_checker - port-level checks of the hash ring
// Watches the command and result ports over time.
// ----------------------------------------------------------------------------
module chr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input chr_pkg::chr_in_t  in_data,
  input logic              out_valid,
  input chr_pkg::chr_out_t out_data
);

  // a non-final key byte gives no result and leaves the block free
  a_byte_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_data.last &&
     (in_data.func == chr_pkg::FUNC_LOOKUP || in_data.func == chr_pkg::FUNC_INSERT))
    |=> (!busy && !out_valid)) else $error("key byte stalled or gave a result");

  // result is a single-cycle strobe
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held for two cycles");

  // result only at the end of a busy phase
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy)) else $error("result outside a busy phase");

  // a result with a non-OK status carries no owner (only lookups set one; remove and clear carry no hash)
  a_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != chr_pkg::ST_OK) |-> out_data.owner_node == 4'd0)
    else $error("owner on a failed result");

endmodule

bind crc32_consistent_hash_ring chr_checker u_chr_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
  .out_valid(out_valid), .out_data(out_data)
);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb - self-checking bench for crc32_consistent_hash_ring
// Streams keys and virtual-node names, removes and clears, predicts every
// result from its own ring model and checks each strobed result in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_SIZE = 256;
  localparam int WDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 300;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  chr_pkg::chr_in_t  in_data = '0;
  logic              out_valid;
  chr_pkg::chr_out_t out_data;

  crc32_consistent_hash_ring i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ring model
  logic [31:0] ring_hash [RING_SIZE];
  logic [3:0]  ring_owner [RING_SIZE];
  int          ring_count = 0;
  logic [31:0] key_crc = chr_pkg::CRC_INIT;

  chr_pkg::chr_in_t  pending_items[$];
  chr_pkg::chr_out_t expected_results[$];
  int       n_sent = 0;
  int       n_checked = 0;
  int       n_errors = 0;
  int       n_full = 0;
  int       n_empty = 0;
  int       sender_idle_pct = 23;
  int       idle_cycles = 0;

  function automatic logic [31:0] fold_byte(logic [31:0] c, logic [7:0] b);
    c = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
    return c;
  endfunction

  // first ring index with hash at or above h
  function automatic int ring_find(logic [31:0] h);
    int idx;
    idx = 0;
    while (idx < ring_count && ring_hash[idx] < h) idx++;
    return idx;
  endfunction

  // apply one transfer to the ring model, queue any result it causes
  task automatic predict_ring(chr_pkg::chr_in_t it);
    chr_pkg::chr_out_t r;
    int idx;
    int w;
    r = '0;
    if (it.func == chr_pkg::FUNC_LOOKUP || it.func == chr_pkg::FUNC_INSERT) begin
      key_crc = fold_byte(key_crc, it.data_byte);
      if (!it.last) return;
      r.hash_value = ~key_crc;
      key_crc = chr_pkg::CRC_INIT;
      idx = ring_find(r.hash_value);
      if (it.func == chr_pkg::FUNC_LOOKUP) begin
        if (ring_count == 0) begin
          r.status = chr_pkg::ST_EMPTY;
          n_empty++;
        end else begin
          if (idx >= ring_count) idx = 0;
          r.owner_node = ring_owner[idx];
        end
      end else if (idx < ring_count && ring_hash[idx] == r.hash_value) begin
        ring_owner[idx] = it.node_id;
      end else if (ring_count >= RING_SIZE) begin
        r.status = chr_pkg::ST_FULL;
        n_full++;
      end else begin
        for (int j = ring_count; j > idx; j--) begin
          ring_hash[j] = ring_hash[j-1];
          ring_owner[j] = ring_owner[j-1];
        end
        ring_hash[idx] = r.hash_value;
        ring_owner[idx] = it.node_id;
        ring_count++;
      end
    end else if (it.func == chr_pkg::FUNC_REMOVE) begin
      key_crc = chr_pkg::CRC_INIT;
      w = 0;
      for (int k = 0; k < ring_count; k++) begin
        if (ring_owner[k] != it.node_id) begin
          ring_hash[w] = ring_hash[k];
          ring_owner[w] = ring_owner[k];
          w++;
        end
      end
      if (w == ring_count) r.status = chr_pkg::ST_NO_NODE;
      ring_count = w;
    end else begin
      key_crc = chr_pkg::CRC_INIT;
      ring_count = 0;
    end
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    n_errors++;
  endtask

  // driver: present items, hold them until accepted
  always @(posedge clk) begin
    logic took;
    took = rst_n && start && !busy;
    if (took) begin
      predict_ring(in_data);
      n_sent++;
    end
    if (rst_n && (!start || took)) begin
      if (pending_items.size() == 0 || $urandom_range(99) < sender_idle_pct) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        in_data <= pending_items.pop_front();
      end
    end
  end

  // monitor: check each strobed result against the oldest expectation
  always @(posedge clk) begin
    chr_pkg::chr_out_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", out_data.hash_value, 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.owner_node !== want.owner_node)
          report_mismatch("owner_node", 32'(out_data.owner_node), 32'(want.owner_node));
        if (out_data.hash_value !== want.hash_value)
          report_mismatch("hash_value", out_data.hash_value, want.hash_value);
        n_checked++;
      end
    end
  end

  // watchdog: cycles with no transfer in either direction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void push_item(logic [1:0] f, logic [7:0] b, logic l, logic [3:0] n);
    chr_pkg::chr_in_t it;
    it.func = f;
    it.data_byte = b;
    it.last = l;
    it.node_id = n;
    pending_items.insert(pending_items.size(), it);
  endfunction

  // random key or name; leading bytes carry a random stream func
  function automatic void push_name(logic [1:0] f, int len, logic [3:0] n);
    for (int k = 0; k < len - 1; k++)
      push_item(2'($urandom_range(1)), 8'($urandom_range(255)), 1'b0,
                4'($urandom_range(15)));
    push_item(f, 8'($urandom_range(255)), 1'b1, n);
  endfunction

  function automatic void push_fill();
    for (int k = 0; k < RING_SIZE; k++)
      push_item(chr_pkg::FUNC_INSERT, k[7:0], 1'b1, 4'($urandom_range(15)));
    push_name(chr_pkg::FUNC_INSERT, 3, 4'($urandom_range(15)));
    push_name(chr_pkg::FUNC_LOOKUP, 2, 4'd0);
  endfunction

  function automatic void push_random(int n);
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 45)
        push_name(chr_pkg::FUNC_LOOKUP, $urandom_range(1, 6), 4'($urandom_range(15)));
      else if (pick < 80)
        push_name(chr_pkg::FUNC_INSERT, $urandom_range(1, 6), 4'($urandom_range(15)));
      else if (pick < 88)
        push_item(chr_pkg::FUNC_REMOVE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  4'($urandom_range(15)));
      else if (pick < 90)
        push_item(chr_pkg::FUNC_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  4'($urandom_range(15)));
      else begin
        // broken sequence: partial key cut off by a remove or a clear
        for (int j = $urandom_range(1, 4); j > 0; j--)
          push_item(2'($urandom_range(1)), 8'($urandom_range(255)), 1'b0,
                    4'($urandom_range(15)));
        push_item($urandom_range(1) ? chr_pkg::FUNC_REMOVE : chr_pkg::FUNC_CLEAR,
                  8'($urandom_range(255)), 1'($urandom_range(1)), 4'($urandom_range(15)));
      end
    end
  endfunction

  initial begin
    // directed part
    push_item(chr_pkg::FUNC_LOOKUP, 8'h00, 1'b1, 4'd0);      // lookup on empty ring
    push_item(chr_pkg::FUNC_INSERT, 8'hFF, 1'b1, 4'd15);
    push_item(chr_pkg::FUNC_INSERT, 8'h00, 1'b1, 4'd1);
    push_item(chr_pkg::FUNC_LOOKUP, 8'h41, 1'b0, 4'd0);      // mixed stream, insert decides
    push_item(chr_pkg::FUNC_INSERT, 8'h42, 1'b1, 4'd5);
    push_item(chr_pkg::FUNC_INSERT, 8'hFF, 1'b1, 4'd3);      // duplicate hash, owner rewritten
    push_item(chr_pkg::FUNC_INSERT, 8'h41, 1'b0, 4'd0);      // mixed stream, lookup decides
    push_item(chr_pkg::FUNC_LOOKUP, 8'h42, 1'b1, 4'd0);
    push_item(chr_pkg::FUNC_LOOKUP, 8'hFF, 1'b1, 4'd0);
    push_item(chr_pkg::FUNC_LOOKUP, 8'h00, 1'b1, 4'd0);
    push_item(chr_pkg::FUNC_LOOKUP, 8'h7E, 1'b1, 4'd0);
    push_item(chr_pkg::FUNC_REMOVE, 8'h00, 1'b0, 4'd7);      // node with no points
    push_item(chr_pkg::FUNC_INSERT, 8'h12, 1'b0, 4'd9);      // partial name, then remove
    push_item(chr_pkg::FUNC_REMOVE, 8'hAA, 1'b1, 4'd3);
    push_item(chr_pkg::FUNC_LOOKUP, 8'h55, 1'b1, 4'd0);
    push_item(chr_pkg::FUNC_LOOKUP, 8'h34, 1'b0, 4'd0);      // partial key, then clear
    push_item(chr_pkg::FUNC_CLEAR,  8'hFF, 1'b1, 4'd15);
    push_item(chr_pkg::FUNC_LOOKUP, 8'h55, 1'b1, 4'd0);
    push_item(chr_pkg::FUNC_INSERT, 8'h10, 1'b1, 4'd10);
    push_item(chr_pkg::FUNC_REMOVE, 8'h00, 1'b0, 4'd10);     // last point removed
    // random part: three phases, the sender idling in the first two and never in the
    // last; a full ring in the first and the last
    push_random(40);
    push_fill();
    push_random(20);
    push_item(chr_pkg::FUNC_CLEAR, 8'h00, 1'b0, 4'd0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 47 : 0;
      if (ph == 1) begin
        push_random(60);
        push_item(chr_pkg::FUNC_CLEAR, 8'h00, 1'b1, 4'd0);
      end else if (ph == 2) begin
        push_random(20);
        push_fill();
        push_random(30);
        push_item(chr_pkg::FUNC_CLEAR, 8'h00, 1'b1, 4'd0);
      end
      while (pending_items.size() != 0 || start) @(posedge clk);
    end
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Transfers sent: %0d, results checked: %0d (ring full %0d, ring empty %0d)",
             n_sent, n_checked, n_full, n_empty);
    $display("Covered lookups, inserts, duplicates, removes, clears and cut-off keys.");
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
